@@ design/sdpe_pkg.sv @@
package sdpe_pkg;

    localparam int PIX_W   = 8;
    localparam int LOW_W   = 9;
    localparam int DIFF_W  = 11;
    localparam int HIGH_W  = 10;
    localparam int Q_W     = 8;
    localparam int QB_W    = 4;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register map: register index sits at paddr[2].
    localparam logic REG_QUANT_BITS = 1'b0;

    localparam logic [QB_W-1:0] QUANT_BITS_RESET = 4'd3;
    localparam logic [QB_W-1:0] QUANT_BITS_MIN   = 4'd1;
    localparam logic [QB_W-1:0] QUANT_BITS_MAX   = 4'd8;

    // Control that the top level hands to every channel slice.
    typedef struct packed {
        logic load;
        logic first;
    } chan_ctl_t;

endpackage

@@ design/subband_dpcm_pixel_encoder_unit.sv @@
// Subband DPCM pixel encoder. Each input beat carries one RGB pixel in scan
// order, with s_tuser marking the first pixel of an image. Per channel the block
// forms the doubled high band (current minus previous sample) and DPCM-codes the
// low band against the previous low band, then picks the nearest level of a
// uniform midrise quantizer with 2^quant_bits levels. On a first pixel the raw
// sample passes through as both bands. The block takes one pixel per clock
// cycle while the master side takes result beats. An accepted pixel sits in
// the input register, moves through the single combinational pass into the
// result register, and is presented on the master side from then on. A
// stalled master side holds both registers, and s_tready drops once both are
// full. Register quant_bits (byte address 0, reset 3) may only be written
// while no pixel is in flight; 0 acts as 1 and values above 8 act as 8. After
// reset the previous pixel and low band read as zero.
module subband_dpcm_pixel_encoder_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // Pixel input.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,   // pix_r[7:0], pix_g[15:8], pix_b[23:16]
    input  logic                          s_tuser,   // first_pixel[0]
    // Result output.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [55:0]                   m_tdata,   // q_r[7:0], q_g[15:8], q_b[23:16],
                                                     // high_r_x2[33:24], high_g_x2[43:34],
                                                     // high_b_x2[53:44], zero[55:54]
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdpe_pkg::PADDR_W-1:0]  paddr,
    input  logic [sdpe_pkg::PDATA_W-1:0]  pwdata,
    output logic [sdpe_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import sdpe_pkg::*;

    logic [QB_W-1:0]  eff_bits;
    logic             in_valid_reg;
    logic             in_valid_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             in_first_reg;
    logic [PIX_W-1:0] in_r_reg;
    logic [PIX_W-1:0] in_g_reg;
    logic [PIX_W-1:0] in_b_reg;
    logic             s_accept;
    logic             advance;
    chan_ctl_t        ctl;

    logic signed [Q_W-1:0]    q_r;
    logic signed [Q_W-1:0]    q_g;
    logic signed [Q_W-1:0]    q_b;
    logic signed [HIGH_W-1:0] high_r_x2;
    logic signed [HIGH_W-1:0] high_g_x2;
    logic signed [HIGH_W-1:0] high_b_x2;

    sdpe_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .eff_bits (eff_bits)
    );

    // The held pixel moves into the result register whenever that register is
    // empty or its beat is being taken this cycle, so both stages stay busy.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_first_reg <= s_tuser;
            in_r_reg     <= s_tdata[7:0];
            in_g_reg     <= s_tdata[15:8];
            in_b_reg     <= s_tdata[23:16];
        end
    end

    assign ctl.load  = advance;
    assign ctl.first = in_first_reg;

    sdpe_chan u_chan_r (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .pix      (in_r_reg),
        .eff_bits (eff_bits),
        .q        (q_r),
        .high_x2  (high_r_x2)
    );

    sdpe_chan u_chan_g (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .pix      (in_g_reg),
        .eff_bits (eff_bits),
        .q        (q_g),
        .high_x2  (high_g_x2)
    );

    sdpe_chan u_chan_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .pix      (in_b_reg),
        .eff_bits (eff_bits),
        .q        (q_b),
        .high_x2  (high_b_x2)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, high_b_x2, high_g_x2, high_r_x2, q_b, q_g, q_r};

`ifndef SYNTHESIS
    // Backpressure on the input only ever comes from a full input register.
    assert property (@(posedge clk) disable iff (!rst_n) !s_tready |-> in_valid_reg)
        else $error("s_tready low with empty input register");

    // A new beat landing on a full input register needs that register to drain.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && in_valid_reg) |-> advance)
        else $error("input beat would overwrite a held pixel");

    // Every pixel moved into the result register shows up as a result beat.
    assert property (@(posedge clk) disable iff (!rst_n) advance |=> m_tvalid)
        else $error("advanced pixel did not produce a result beat");

    // The quantizer only ever sees a level count it supports.
    assert property (@(posedge clk) disable iff (!rst_n)
        (eff_bits >= QUANT_BITS_MIN) && (eff_bits <= QUANT_BITS_MAX))
        else $error("effective quant_bits out of range");
`endif

endmodule

@@ design/sdpe_cfg.sv @@
module sdpe_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdpe_pkg::PADDR_W-1:0]  paddr,
    input  logic [sdpe_pkg::PDATA_W-1:0]  pwdata,
    output logic [sdpe_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [sdpe_pkg::QB_W-1:0]     eff_bits
);
    import sdpe_pkg::*;

    logic [QB_W-1:0] quant_bits_reg;
    logic [QB_W-1:0] quant_bits_next;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_QUANT_BITS);

    always_comb
    begin
        quant_bits_next = quant_bits_reg;
        if (wr_en)
        begin
            quant_bits_next = pwdata[QB_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quant_bits_reg <= QUANT_BITS_RESET;
        end
        else
        begin
            quant_bits_reg <= quant_bits_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_QUANT_BITS)
        begin
            prdata = {{(PDATA_W-QB_W){1'b0}}, quant_bits_reg};
        end
    end

    // Zero behaves as one level bit and anything above eight as eight.
    always_comb
    begin
        if (quant_bits_reg < QUANT_BITS_MIN)
        begin
            eff_bits = QUANT_BITS_MIN;
        end
        else if (quant_bits_reg > QUANT_BITS_MAX)
        begin
            eff_bits = QUANT_BITS_MAX;
        end
        else
        begin
            eff_bits = quant_bits_reg;
        end
    end

endmodule

@@ design/sdpe_quant.sv @@
module sdpe_quant (
    input  logic signed [sdpe_pkg::DIFF_W-1:0] diff4,
    input  logic        [sdpe_pkg::QB_W-1:0]   eff_bits,
    output logic signed [sdpe_pkg::Q_W-1:0]    level
);
    import sdpe_pkg::*;

    logic        [QB_W-1:0]   sh;
    logic signed [DIFF_W-1:0] off;
    logic signed [DIFF_W-1:0] u;
    logic signed [DIFF_W-1:0] j_lo;
    logic signed [DIFF_W-1:0] j_sel;
    logic signed [DIFF_W-1:0] half;
    logic signed [DIFF_W-1:0] j_clip;
    logic signed [DIFF_W-1:0] lvl_wide;
    logic signed [DIFF_W-1:0] fl8;
    logic        [HIGH_W-1:0] span;
    logic        [HIGH_W-1:0] rem;
    logic        [HIGH_W-1:0] rem_up;
    logic                     pick_hi;

    // Levels sit on the grid k*j + k/2 with k = 256 >> bits; in quarter units the
    // grid pitch is 2^(10-bits). Only the two levels around the value can win.
    always_comb
    begin
        sh       = QB_W'(10) - eff_bits;
        off      = DIFF_W'(1) << (QB_W'(9) - eff_bits);
        u        = diff4 - off;
        j_lo     = u >>> sh;
        span     = HIGH_W'(1) << sh;
        rem      = u[HIGH_W-1:0] & (span - HIGH_W'(1));
        rem_up   = span - rem;
        pick_hi  = (rem >> 2) > (rem_up >> 2);
        j_sel    = j_lo + DIFF_W'(pick_hi);
        half     = DIFF_W'(1) << (eff_bits - QB_W'(1));
        if (j_sel < -half)
        begin
            j_clip = -half;
        end
        else if (j_sel > half - DIFF_W'(1))
        begin
            j_clip = half - DIFF_W'(1);
        end
        else
        begin
            j_clip = j_sel;
        end
        lvl_wide = (j_clip << (QB_W'(8) - eff_bits)) + (DIFF_W'(1) << (QB_W'(7) - eff_bits));

        // With eight bits the levels are the integers from -127 to 127, so the
        // floor of the value always wins, held off the missing -128.
        fl8 = diff4 >>> 2;
        if (fl8 < -DIFF_W'(127))
        begin
            fl8 = -DIFF_W'(127);
        end

        if (eff_bits == QUANT_BITS_MAX)
        begin
            level = fl8[Q_W-1:0];
        end
        else
        begin
            level = lvl_wide[Q_W-1:0];
        end
    end

endmodule

@@ design/sdpe_chan.sv @@
module sdpe_chan (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sdpe_pkg::chan_ctl_t                 ctl,
    input  logic        [sdpe_pkg::PIX_W-1:0]   pix,
    input  logic        [sdpe_pkg::QB_W-1:0]    eff_bits,
    output logic signed [sdpe_pkg::Q_W-1:0]     q,
    output logic signed [sdpe_pkg::HIGH_W-1:0]  high_x2
);
    import sdpe_pkg::*;

    logic        [PIX_W-1:0]  last_pix_reg;
    logic        [LOW_W-1:0]  last_low_reg;
    logic        [LOW_W-1:0]  low_next;
    logic signed [DIFF_W-1:0] diff4;
    logic signed [Q_W-1:0]    q_lvl;
    logic signed [Q_W-1:0]    q_next;
    logic signed [HIGH_W-1:0] high_next;
    logic signed [Q_W-1:0]    q_reg;
    logic signed [HIGH_W-1:0] high_reg;

    always_comb
    begin
        if (ctl.first)
        begin
            low_next  = {pix, 1'b0};
            high_next = {1'b0, pix, 1'b0};
        end
        else
        begin
            low_next  = LOW_W'(pix) + LOW_W'(last_pix_reg);
            high_next = HIGH_W'(pix) - HIGH_W'(last_pix_reg);
        end
        diff4 = $signed(DIFF_W'(low_next)) - $signed(DIFF_W'(last_low_reg));
    end

    sdpe_quant u_quant (
        .diff4    (diff4),
        .eff_bits (eff_bits),
        .level    (q_lvl)
    );

    assign q_next = ctl.first ? $signed(pix) : q_lvl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pix_reg <= '0;
            last_low_reg <= '0;
        end
        else if (ctl.load)
        begin
            last_pix_reg <= pix;
            last_low_reg <= low_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            q_reg    <= q_next;
            high_reg <= high_next;
        end
    end

    assign q       = q_reg;
    assign high_x2 = high_reg;

endmodule
